// File: rtl/core/dili_pkg.sv
package dili_pkg;

  // parse position within the packed list
  typedef enum logic [2:0] {
    PH_COUNT  = 3'd0,
    PH_CMD    = 3'd1,
    PH_ARGCNT = 3'd2,
    PH_ARGS   = 3'd3,
    PH_DELAY  = 3'd4
  } phase_e;

  // kind of result sent downstream
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DELAY = 2'd2
  } kind_e;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ArgW   = 7;
  localparam int unsigned MsW    = 9;
  localparam int unsigned TdataW = 24;

  localparam logic [ByteW-1:0] LongCode = 8'd255;
  localparam logic [MsW-1:0]   LongMs   = 9'd500;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [MsW-1:0]   ms;
    logic             done;
  } result_t;

endpackage

// File: rtl/core/dili_decode.sv
module dili_decode import dili_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] list_byte_i,
  input  logic             list_start_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] cmds_q, cmds_d;
  logic [ArgW-1:0]  args_q, args_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             dly_q, dly_d;

  logic [ByteW-1:0] cmds_dec;
  logic [ArgW-1:0]  args_dec;
  logic             fin_done;

  // decrement helpers, saturating at zero
  assign cmds_dec = (cmds_q != '0) ? cmds_q - 1'b1 : '0;
  assign args_dec = (args_q != '0) ? args_q - 1'b1 : '0;
  assign fin_done = (cmds_dec == '0);

  always_comb begin
    phase_d     = phase_q;
    cmds_d      = cmds_q;
    args_d      = args_q;
    held_d      = held_q;
    dly_d       = dly_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (list_start_i || phase_q == PH_COUNT) begin
      // count byte: resync
      cmds_d  = list_byte_i;
      args_d  = '0;
      dly_d   = 1'b0;
      held_d  = '0;
      phase_d = (list_byte_i == '0) ? PH_COUNT : PH_CMD;
    end else begin
      case (phase_q)
        PH_CMD: begin
          held_d  = list_byte_i;
          phase_d = PH_ARGCNT;
        end
        PH_ARGCNT: begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_CMD;
          res_o.data  = held_q;
          args_d      = list_byte_i[ArgW-1:0];
          dly_d       = list_byte_i[ByteW-1];
          if (list_byte_i[ArgW-1:0] != '0) begin
            phase_d = PH_ARGS;
          end else if (list_byte_i[ByteW-1]) begin
            phase_d = PH_DELAY;
          end else begin
            cmds_d     = cmds_dec;
            args_d     = '0;
            dly_d      = 1'b0;
            phase_d    = fin_done ? PH_COUNT : PH_CMD;
            res_o.done = fin_done;
          end
        end
        PH_ARGS: begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_DATA;
          res_o.data  = list_byte_i;
          args_d      = args_dec;
          if (args_dec == '0) begin
            if (dly_q) begin
              phase_d = PH_DELAY;
            end else begin
              cmds_d     = cmds_dec;
              dly_d      = 1'b0;
              phase_d    = fin_done ? PH_COUNT : PH_CMD;
              res_o.done = fin_done;
            end
          end
        end
        PH_DELAY: begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_DELAY;
          res_o.ms    = (list_byte_i == LongCode) ? LongMs : {1'b0, list_byte_i};
          cmds_d      = cmds_dec;
          args_d      = '0;
          dly_d       = 1'b0;
          phase_d     = fin_done ? PH_COUNT : PH_CMD;
          res_o.done  = fin_done;
        end
        default: begin
          cmds_d  = list_byte_i;
          args_d  = '0;
          dly_d   = 1'b0;
          held_d  = '0;
          phase_d = (list_byte_i == '0) ? PH_COUNT : PH_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      cmds_q  <= '0;
      args_q  <= '0;
      held_q  <= '0;
      dly_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cmds_q  <= cmds_d;
      args_q  <= args_d;
      held_q  <= held_d;
      dly_q   <= dly_d;
    end
  end

endmodule

// File: rtl/core/display_init_list_interpreter.sv
// display init list interpreter
//
// slave stream: one byte of the packed init list per transfer in tdata;
// tuser set forces the byte to be read as the command count (resync).
// the list is a count, then per command: command byte, argument-count byte
// (bit 7 asks for a delay), the arguments, and an optional delay byte.
// master stream: tuser gives the kind (command, data, delay request),
// tdata holds the byte to send and the wait in ms (255 maps to 500),
// tlast marks the final result of the whole list.
// each input byte yields zero or one result; the command byte is held until
// its argument-count byte arrives so that tlast can sit on it.
// a result is registered in the output register, or the skid entry while the
// receiver stalls. throughput: one byte per cycle while tready is high, set
// by combinational parse logic between parser state and output register.
// a two-entry output register (main + skid) decouples the sides: tready
// drops only once both entries are full while the receiver stalls.
// reset clears the parser to "expect count byte" and empties the output.
module display_init_list_interpreter import dili_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,   // [7:0] list_byte
  input  logic [0:0]        s_axis_tuser,   // [0] list_start
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,   // [7:0] out_byte, [16:8] delay_ms, rest zero
  output logic [1:0]        m_axis_tuser,   // [1:0] out_kind
  output logic              m_axis_tlast    // list_done
);

  logic    accept;
  logic    res_valid;
  result_t res;

  // output register and skid entry
  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    push, pop;

  assign s_axis_tready = !skid_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dili_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .list_byte_i  (s_axis_tdata),
    .list_start_i (s_axis_tuser[0]),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign push = accept && res_valid;
  assign pop  = out_vld_q && m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        // refill from skid entry
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    // push only happens while the skid entry is empty
    if (push) begin
      if (!out_vld_q || pop) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(TdataW - ByteW - MsW){1'b0}}, out_q.ms, out_q.data};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.done;

endmodule
